// File: design/sfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared widths, register indexes, reset values and the queue entry type of
// the stepper speed to step period converter.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int SPEED_IN_W   = 16;
  localparam int SPEED_W      = 15;
  localparam int FACTOR_W     = 20;
  localparam int PERIOD_OUT_W = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 20;
  localparam int QUEUE_DEPTH  = 2;

  localparam int FRAC_BITS_DEF    = 8;
  localparam int PERIOD_WIDTH_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_THRESH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_SWITCH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_FACTOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_FACTOR = 3'd5;

  localparam logic [SPEED_W-1:0]      MIN_SPEED_RST   = 15'd1024;
  localparam logic [SPEED_W-1:0]      MAX_SPEED_RST   = 15'd6400;
  localparam logic [SPEED_W-1:0]      OFF_THRESH_RST  = 15'd3;
  localparam logic [SPEED_W-1:0]      MODE_SWITCH_RST = 15'd3200;
  localparam logic [FACTOR_W-1:0]     HALF_FACTOR_RST = 20'd150000;
  localparam logic [FACTOR_W-1:0]     FULL_FACTOR_RST = 20'd300000;
  localparam logic [PERIOD_OUT_W-1:0] HELD_PERIOD_RST = 16'd15000;

  typedef struct packed {
    logic                motor_on;
    logic                half_step;
    logic                forward;
    logic [FACTOR_W-1:0] factor;
    logic [SPEED_W-1:0]  mag;
  } op_t;

endpackage : sfp_pkg
`default_nettype wire

// File: design/sfp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_front
// Configuration registers and item classification: magnitude, clamp, off
// test, raise to minimum, step mode, direction and factor selection.
// ----------------------------------------------------------------------------
module sfp_front (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_valid_i,
  input  wire  [sfp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire  [sfp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire  signed [sfp_pkg::SPEED_IN_W-1:0] speed_i,
  output sfp_pkg::op_t                         op_o
);
  import sfp_pkg::*;

  logic [SPEED_W-1:0]  min_speed_q, max_speed_q, off_thresh_q, mode_switch_q;
  logic [FACTOR_W-1:0] half_factor_q, full_factor_q;

  logic [SPEED_IN_W-1:0] raw;
  logic [SPEED_IN_W-1:0] mag_full;
  logic [SPEED_W-1:0]    mag_clamp;
  logic [SPEED_W-1:0]    mag_raised;
  logic                  half_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q   <= MIN_SPEED_RST;
      max_speed_q   <= MAX_SPEED_RST;
      off_thresh_q  <= OFF_THRESH_RST;
      mode_switch_q <= MODE_SWITCH_RST;
      half_factor_q <= HALF_FACTOR_RST;
      full_factor_q <= FULL_FACTOR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_SPEED:   min_speed_q   <= cfg_data_i[SPEED_W-1:0];
        CFG_MAX_SPEED:   max_speed_q   <= cfg_data_i[SPEED_W-1:0];
        CFG_OFF_THRESH:  off_thresh_q  <= cfg_data_i[SPEED_W-1:0];
        CFG_MODE_SWITCH: mode_switch_q <= cfg_data_i[SPEED_W-1:0];
        CFG_HALF_FACTOR: half_factor_q <= cfg_data_i[FACTOR_W-1:0];
        CFG_FULL_FACTOR: full_factor_q <= cfg_data_i[FACTOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    raw      = speed_i;
    mag_full = raw[SPEED_IN_W-1] ? (~raw + 1'b1) : raw;
    if (mag_full > {1'b0, max_speed_q}) begin
      mag_clamp = max_speed_q;
    end else begin
      mag_clamp = mag_full[SPEED_W-1:0];
    end
    mag_raised = (mag_clamp < min_speed_q) ? min_speed_q : mag_clamp;
    half_step  = mag_raised < mode_switch_q;

    op_o.motor_on  = mag_clamp >= off_thresh_q;
    op_o.half_step = half_step;
    op_o.forward   = !raw[SPEED_IN_W-1] && (raw != '0);
    op_o.factor    = half_step ? half_factor_q : full_factor_q;
    op_o.mag       = mag_raised;
  end

endmodule : sfp_front
`default_nettype wire

// File: design/sfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_queue
// Short FIFO of classified items between the front and the divider back end.
// ----------------------------------------------------------------------------
module sfp_queue (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_i,
  input  sfp_pkg::op_t  push_data_i,
  output logic          full_o,
  input  wire           pop_i,
  output sfp_pkg::op_t  pop_data_o,
  output logic          empty_o
);
  import sfp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o     = count_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule : sfp_queue
`default_nettype wire

// File: design/sfp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_back
// Bit-serial restoring divider for the step period, held drive state and the
// output register.
// ----------------------------------------------------------------------------
module sfp_back #(
  parameter int FRAC_BITS    = sfp_pkg::FRAC_BITS_DEF,
  parameter int PERIOD_WIDTH = sfp_pkg::PERIOD_WIDTH_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               empty_i,
  input  sfp_pkg::op_t                      op_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic                              motor_on_o,
  output logic                              half_step_mode_o,
  output logic                              direction_forward_o,
  output logic [sfp_pkg::PERIOD_OUT_W-1:0]  step_period_o,
  output logic                              period_updated_o
);
  import sfp_pkg::*;

  localparam int NUM_W = FACTOR_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} state_e;

  state_e                  state_q;
  op_t                     op_q;
  logic [NUM_W-1:0]        num_q;
  logic [SPEED_W-1:0]      rem_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    held_half_q, held_dir_q;
  logic [PERIOD_OUT_W-1:0] held_period_q;

  logic [SPEED_W:0]        rem_shift, rem_sub;
  logic                    ge, last, overflow, out_free, out_load;
  logic [SPEED_W-1:0]      rem_next;
  logic [NUM_W-1:0]        num_next;
  logic [PERIOD_OUT_W-1:0] period;

  always_comb begin
    rem_shift = {rem_q, num_q[NUM_W-1]};
    ge        = rem_shift >= {1'b0, op_q.mag};
    rem_sub   = rem_shift - {1'b0, op_q.mag};
    rem_next  = ge ? rem_sub[SPEED_W-1:0] : rem_shift[SPEED_W-1:0];
    num_next  = {num_q[NUM_W-2:0], ge};
    last      = cnt_q == CNT_W'(NUM_W - 1);
    overflow  = ((num_next >> PERIOD_WIDTH) != '0) || (op_q.mag == '0);
    period    = overflow ? '1 : num_next[PERIOD_OUT_W-1:0];
    out_free  = !out_valid_o || !out_stall_i;
    out_load  = (state_q == S_PUSH) && out_free;
    pop_o     = (state_q == S_IDLE) && !empty_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= S_IDLE;
      op_q                <= '0;
      num_q               <= '0;
      rem_q               <= '0;
      cnt_q               <= '0;
      held_half_q         <= 1'b0;
      held_dir_q          <= 1'b0;
      held_period_q       <= HELD_PERIOD_RST;
      out_valid_o         <= 1'b0;
      motor_on_o          <= 1'b0;
      half_step_mode_o    <= 1'b0;
      direction_forward_o <= 1'b0;
      step_period_o       <= '0;
      period_updated_o    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            op_q  <= op_i;
            num_q <= {op_i.factor, FRAC_BITS'(0)};
            rem_q <= '0;
            cnt_q <= '0;
            state_q <= op_i.motor_on ? S_DIV : S_PUSH;
          end
        end
        S_DIV: begin
          num_q <= num_next;
          rem_q <= rem_next;
          cnt_q <= cnt_q + 1'b1;
          if (last) begin
            held_half_q   <= op_q.half_step;
            held_dir_q    <= op_q.forward;
            held_period_q <= period;
            state_q       <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            motor_on_o          <= op_q.motor_on;
            half_step_mode_o    <= held_half_q;
            direction_forward_o <= held_dir_q;
            step_period_o       <= held_period_q;
            period_updated_o    <= op_q.motor_on;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule : sfp_back
`default_nettype wire

// File: design/stepper_speed_to_step_period.sv
`timescale 1ns / 1ps
`default_nettype none
// A running item passes through the queue, the serial divider (one quotient bit per
// cycle) and the output register, which holds its result while stalled. The back end
// takes a new item only once the last one is in the output register; a motor-off item
// skips the divider. A two-item queue decouples input.
// Reset: registers return to their defaults, held mode and direction clear, held
// period 15000, queue and output register empty.
// ----------------------------------------------------------------------------
// stepper_speed_to_step_period
// Converts a signed track speed into motor enable, step mode, direction and
// a saturated timer reload period.
// ----------------------------------------------------------------------------
module stepper_speed_to_step_period #(
  parameter int FRAC_BITS    = sfp_pkg::FRAC_BITS_DEF,
  parameter int PERIOD_WIDTH = sfp_pkg::PERIOD_WIDTH_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [sfp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire  [sfp_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  signed [sfp_pkg::SPEED_IN_W-1:0] speed_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic                                  motor_on_o,
  output logic                                  half_step_mode_o,
  output logic                                  direction_forward_o,
  output logic [sfp_pkg::PERIOD_OUT_W-1:0]      step_period_o,
  output logic                                  period_updated_o
);
  import sfp_pkg::*;

  op_t  front_op, back_op;
  logic q_full, q_empty, q_pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  sfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .speed_i     (speed_i),
    .op_o        (front_op)
  );

  sfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_op),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (back_op),
    .empty_o     (q_empty)
  );

  sfp_back #(
    .FRAC_BITS    (FRAC_BITS),
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .empty_i             (q_empty),
    .op_i                (back_op),
    .pop_o               (q_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .motor_on_o          (motor_on_o),
    .half_step_mode_o    (half_step_mode_o),
    .direction_forward_o (direction_forward_o),
    .step_period_o       (step_period_o),
    .period_updated_o    (period_updated_o)
  );

endmodule : stepper_speed_to_step_period
`default_nettype wire

// File: test/stepper_speed_to_step_period_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_speed_to_step_period_tb
// Drives signed speed items through the converter under several register
// settings and random idling on both sides. A local model predicts motor
// enable, step mode, direction and period for each item and the result
// stream is checked against it in order.
// ----------------------------------------------------------------------------
module stepper_speed_to_step_period_tb;
  import sfp_pkg::*;

  localparam int          HALF_PERIOD  = 2;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          CHUNK_ITEMS  = 80;
  localparam int          SPEED_TOP    = 32767;
  localparam int          FACTOR_TOP   = (1 << FACTOR_W) - 1;
  localparam longint unsigned PERIOD_MAX = (64'd1 << PERIOD_WIDTH_DEF) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LOW = CFG_FULL_FACTOR + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_TOP = {CFG_IDX_W{1'b1}};

  typedef struct packed {
    logic                    motor_on;
    logic                    half_step;
    logic                    forward;
    logic [PERIOD_OUT_W-1:0] period;
    logic                    updated;
  } step_cmd_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i  = '0;
  logic                    in_valid_i  = 1'b0;
  logic signed [SPEED_IN_W-1:0] speed_i = '0;
  logic                    out_stall_i = 1'b0;
  logic                    cfg_ready_o;
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic                    motor_on_o;
  logic                    half_step_mode_o;
  logic                    direction_forward_o;
  logic [PERIOD_OUT_W-1:0] step_period_o;
  logic                    period_updated_o;

  // register shadows and held drive state
  logic [SPEED_W-1:0]      min_speed_r   = MIN_SPEED_RST;
  logic [SPEED_W-1:0]      max_speed_r   = MAX_SPEED_RST;
  logic [SPEED_W-1:0]      off_thresh_r  = OFF_THRESH_RST;
  logic [SPEED_W-1:0]      mode_switch_r = MODE_SWITCH_RST;
  logic [FACTOR_W-1:0]     half_factor_r = HALF_FACTOR_RST;
  logic [FACTOR_W-1:0]     full_factor_r = FULL_FACTOR_RST;
  logic                    held_half     = 1'b0;
  logic                    held_fwd      = 1'b0;
  logic [PERIOD_OUT_W-1:0] held_period   = HELD_PERIOD_RST;

  step_cmd_t expected_cmds[$];
  int        errors        = 0;
  int        cycles        = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_reqs     = 0;
  int        hold_seen     = 0;
  int        hold_left     = 0;

  stepper_speed_to_step_period u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .speed_i             (speed_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .motor_on_o          (motor_on_o),
    .half_step_mode_o    (half_step_mode_o),
    .direction_forward_o (direction_forward_o),
    .step_period_o       (step_period_o),
    .period_updated_o    (period_updated_o)
  );

  initial begin
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall plus a long counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left--;
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  function automatic step_cmd_t predict_step(input logic signed [SPEED_IN_W-1:0] speed);
    logic [SPEED_IN_W-1:0] raw;
    logic [SPEED_IN_W:0]   mag;
    logic [FACTOR_W-1:0]   factor;
    longint unsigned       quot;
    step_cmd_t             cmd;
    raw = speed;
    mag = raw[SPEED_IN_W-1] ? ((17'd1 << SPEED_IN_W) - {1'b0, raw}) : {1'b0, raw};
    cmd.motor_on = 1'b0;
    cmd.updated  = 1'b0;
    if (mag > {2'b00, max_speed_r}) mag = {2'b00, max_speed_r};
    if (mag >= {2'b00, off_thresh_r}) begin
      cmd.motor_on = 1'b1;
      cmd.updated  = 1'b1;
      if (mag < {2'b00, min_speed_r}) mag = {2'b00, min_speed_r};
      held_half = (mag < {2'b00, mode_switch_r});
      factor    = held_half ? half_factor_r : full_factor_r;
      if (mag == 0) begin
        quot = PERIOD_MAX;
      end else begin
        quot = (longint'(factor) << FRAC_BITS_DEF) / mag;
        if (quot > PERIOD_MAX) quot = PERIOD_MAX;
      end
      held_period = quot[PERIOD_OUT_W-1:0];
      held_fwd    = !raw[SPEED_IN_W-1] && (raw != 0);
    end
    cmd.half_step = held_half;
    cmd.forward   = held_fwd;
    cmd.period    = held_period;
    return cmd;
  endfunction

  task automatic check_field(input string name, input logic [PERIOD_OUT_W-1:0] exp_v,
                             input logic [PERIOD_OUT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    step_cmd_t exp_cmd;
    if (out_valid_o && !out_stall_i) begin
      if (expected_cmds.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none actual period %0d",
                 $time, step_period_o);
      end else begin
        exp_cmd = expected_cmds.pop_front();
        check_field("motor_on", PERIOD_OUT_W'(exp_cmd.motor_on), PERIOD_OUT_W'(motor_on_o));
        check_field("half_step_mode", PERIOD_OUT_W'(exp_cmd.half_step),
                    PERIOD_OUT_W'(half_step_mode_o));
        check_field("direction_forward", PERIOD_OUT_W'(exp_cmd.forward),
                    PERIOD_OUT_W'(direction_forward_o));
        check_field("step_period", exp_cmd.period, step_period_o);
        check_field("period_updated", PERIOD_OUT_W'(exp_cmd.updated),
                    PERIOD_OUT_W'(period_updated_o));
      end
    end
  end

  task automatic send_speed(input logic signed [SPEED_IN_W-1:0] speed);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    speed_i    <= speed;
    do @(posedge clk_i); while (in_stall_o);
    expected_cmds.push_back(predict_step(speed));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MIN_SPEED:   min_speed_r   = data[SPEED_W-1:0];
      CFG_MAX_SPEED:   max_speed_r   = data[SPEED_W-1:0];
      CFG_OFF_THRESH:  off_thresh_r  = data[SPEED_W-1:0];
      CFG_MODE_SWITCH: mode_switch_r = data[SPEED_W-1:0];
      CFG_HALF_FACTOR: half_factor_r = data[FACTOR_W-1:0];
      CFG_FULL_FACTOR: full_factor_r = data[FACTOR_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int pick_value(input int lo, input int hi, input int typ_hi);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return lo;
    if (sel == 1) return hi;
    return $urandom_range(lo, typ_hi);
  endfunction

  task automatic randomise_regs();
    write_reg(CFG_MIN_SPEED,   CFG_DATA_W'(pick_value(1, SPEED_TOP, 4096)));
    write_reg(CFG_MAX_SPEED,   CFG_DATA_W'(pick_value(1, SPEED_TOP, SPEED_TOP)));
    write_reg(CFG_OFF_THRESH,  CFG_DATA_W'(pick_value(0, SPEED_TOP, 64)));
    write_reg(CFG_MODE_SWITCH, CFG_DATA_W'(pick_value(0, SPEED_TOP, 8192)));
    write_reg(CFG_HALF_FACTOR, CFG_DATA_W'(pick_value(1, FACTOR_TOP, FACTOR_TOP)));
    write_reg(CFG_FULL_FACTOR, CFG_DATA_W'(pick_value(1, FACTOR_TOP, FACTOR_TOP)));
  endtask

  function automatic logic signed [SPEED_IN_W-1:0] random_speed();
    int m;
    case ($urandom_range(4))
      0:       return SPEED_IN_W'($urandom);
      1:       m = $urandom_range(0, 2 * off_thresh_r + 2);
      2:       m = mode_switch_r + $urandom_range(0, 8) - 4;
      3:       m = max_speed_r + $urandom_range(0, 8) - 4;
      default: m = $urandom_range(0, max_speed_r + 16);
    endcase
    if (m < 0) m = 0;
    if (m > SPEED_TOP) m = SPEED_TOP;
    return $urandom_range(1) ? SPEED_IN_W'(-m) : SPEED_IN_W'(m);
  endfunction

  task automatic test_reset_defaults();
    logic signed [SPEED_IN_W-1:0] speeds[$] = '{0, 2, 3, -3, 1, -1, 32767, -32768,
                                                  6401, 1023, 3199, 3200, -3200, 0};
    foreach (speeds[i]) send_speed(speeds[i]);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    // masked write: min above max, raise wins
    write_reg(CFG_MIN_SPEED, {CFG_DATA_W{1'b1}});
    write_reg(CFG_MAX_SPEED, 1);
    write_reg(CFG_OFF_THRESH, 0);
    write_reg(CFG_MODE_SWITCH, SPEED_TOP);
    send_speed(0);
    send_speed(-32768);
    wait_drained();
    // zero magnitude after raise saturates the period
    write_reg(CFG_MIN_SPEED, 0);
    write_reg(CFG_MAX_SPEED, SPEED_TOP);
    send_speed(0);
    send_speed(5);
    wait_drained();
    // quotient overflow and smallest quotient
    write_reg(CFG_HALF_FACTOR, FACTOR_TOP);
    write_reg(CFG_FULL_FACTOR, 1);
    send_speed(1);
    send_speed(-SPEED_TOP);
    wait_drained();
    write_reg(CFG_MODE_SWITCH, 0);
    write_reg(CFG_OFF_THRESH, SPEED_TOP);
    write_reg(CFG_SPARE_LOW, 0);
    write_reg(CFG_SPARE_TOP, {CFG_DATA_W{1'b1}});
    send_speed(SPEED_TOP);
    send_speed(100);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
    int sent;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < n_items) begin
      randomise_regs();
      repeat (CHUNK_ITEMS) begin
        send_speed(random_speed());
        sent++;
      end
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    randomise_regs();
    @(posedge clk_i);
    hold_reqs++;
    repeat (20) send_speed(random_speed());
    wait_drained();
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic(17, 84, 320);
    test_random_traffic(84, 17, 320);
    test_random_traffic(0, 0, 320);
    test_backpressure();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: stepper_speed_to_step_period.f
design/sfp_pkg.sv
design/sfp_front.sv
design/sfp_queue.sv
design/sfp_back.sv
design/stepper_speed_to_step_period.sv
test/stepper_speed_to_step_period_tb.sv
